FILE: hw/rtl/cfa_sm9_pkg.sv
// cfa_sm9_pkg: shared types, constants and the median network tables
// for the same-color median9 filter
// no dependencies

package cfa_sm9_pkg;

    localparam int unsigned DATA_W         = 16;
    localparam int unsigned CFG_AW         = 3;
    localparam int unsigned CFG_DW         = 32;
    localparam int unsigned ROW_W          = 15;
    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned PIXEL_BITS_DEF = 16;
    localparam int unsigned MIN_DIM        = 5;
    localparam int unsigned HEIGHT_CAP     = 16384;
    localparam int unsigned WIDTH_RESET    = 1920;
    localparam int unsigned HEIGHT_RESET   = 1080;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] pixel_in;
        logic              pad;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] pixel_out;
        logic              end_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [ROW_W-1:0] h_m1;
        logic [ROW_W-1:0] h_p2;
        logic             restart;
    } t_frame_geom;

    typedef struct packed {
        logic interior;
        logic eof;
    } t_sort_ctl;

    // compare-exchange network: min goes to the first index, max to the second
    localparam int unsigned NET_LAYERS = 9;
    localparam int unsigned NET_PAIRS  = 3;

    localparam logic [3:0] NET_I [NET_LAYERS][NET_PAIRS] = '{
        '{4'd1, 4'd4, 4'd7},
        '{4'd0, 4'd3, 4'd6},
        '{4'd1, 4'd4, 4'd7},
        '{4'd0, 4'd5, 4'd4},
        '{4'd3, 4'd1, 4'd2},
        '{4'd4, 4'd0, 4'd0},
        '{4'd4, 4'd0, 4'd0},
        '{4'd6, 4'd0, 4'd0},
        '{4'd4, 4'd0, 4'd0}
    };

    localparam logic [3:0] NET_J [NET_LAYERS][NET_PAIRS] = '{
        '{4'd2, 4'd5, 4'd8},
        '{4'd1, 4'd4, 4'd7},
        '{4'd2, 4'd5, 4'd8},
        '{4'd3, 4'd8, 4'd7},
        '{4'd6, 4'd4, 4'd5},
        '{4'd7, 4'd0, 4'd0},
        '{4'd2, 4'd0, 4'd0},
        '{4'd4, 4'd0, 4'd0},
        '{4'd2, 4'd0, 4'd0}
    };

    localparam logic [1:0] NET_CNT [NET_LAYERS] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1
    };

    function automatic logic [ROW_W-1:0] clamp_width(input logic [12:0] raw,
                                                     input int unsigned maxw);
        logic [ROW_W-1:0] w;
        w = ROW_W'(raw);
        if (w < ROW_W'(MIN_DIM)) w = ROW_W'(MIN_DIM);
        if (w > ROW_W'(maxw)) w = ROW_W'(maxw);
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] raw);
        logic [ROW_W-1:0] h;
        h = raw;
        if (h < ROW_W'(MIN_DIM)) h = ROW_W'(MIN_DIM);
        if (h > ROW_W'(HEIGHT_CAP)) h = ROW_W'(HEIGHT_CAP);
        return h;
    endfunction

endpackage

FILE: hw/rtl/cfa_sm9_cfg.sv
// cfa_sm9_cfg: apb register file for line width and frame height,
// keeps the clamped frame geometry; uses cfa_sm9_pkg

module cfa_sm9_cfg #(
    parameter int unsigned MAX_WIDTH = cfa_sm9_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfa_sm9_pkg::CFG_AW-1:0]    paddr,
    input  logic [cfa_sm9_pkg::CFG_DW-1:0]    pwdata,
    output logic [cfa_sm9_pkg::CFG_DW-1:0]    prdata,
    output logic                              pready,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_w_m1,
    output cfa_sm9_pkg::t_frame_geom          o_geom
);
    import cfa_sm9_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    logic [12:0]      r_line_width;
    logic [ROW_W-1:0] r_frame_height;
    logic [COL_W-1:0] r_w_m1;
    logic [ROW_W-1:0] r_h_m1;
    logic [ROW_W-1:0] r_h_p2;
    logic [ROW_W-1:0] w_width;
    logic [ROW_W-1:0] w_height;
    logic             w_wr;
    t_reg_idx         w_idx;

    assign w_wr     = psel && penable && pwrite;
    assign w_idx    = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_width  = clamp_width(pwdata[12:0], MAX_WIDTH);
    assign w_height = clamp_height(pwdata[ROW_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= 13'(WIDTH_RESET);
            r_frame_height <= ROW_W'(HEIGHT_RESET);
            r_w_m1         <= COL_W'(clamp_width(13'(WIDTH_RESET), MAX_WIDTH) - ROW_W'(1));
            r_h_m1         <= clamp_height(ROW_W'(HEIGHT_RESET)) - ROW_W'(1);
            r_h_p2         <= clamp_height(ROW_W'(HEIGHT_RESET)) + ROW_W'(2);
        end else if (w_wr) begin
            case (w_idx)
                REG_LINE_WIDTH: begin
                    r_line_width <= pwdata[12:0];
                    r_w_m1       <= COL_W'(w_width - ROW_W'(1));
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[ROW_W-1:0];
                    r_h_m1         <= w_height - ROW_W'(1);
                    r_h_p2         <= w_height + ROW_W'(2);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LINE_WIDTH:   prdata = CFG_DW'(r_line_width);
            REG_FRAME_HEIGHT: prdata = CFG_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_w_m1         = r_w_m1;
    assign o_geom.h_m1    = r_h_m1;
    assign o_geom.h_p2    = r_h_p2;
    assign o_geom.restart = w_wr;

endmodule

FILE: hw/rtl/cfa_sm9_front.sv
// cfa_sm9_front: raster counters, four-line store memory and 5x5 window
// rows feeding the median network; uses cfa_sm9_pkg

module cfa_sm9_front #(
    parameter int unsigned MAX_WIDTH  = cfa_sm9_pkg::MAX_WIDTH_DEF,
    parameter int unsigned PIXEL_BITS = cfa_sm9_pkg::PIXEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_w_m1,
    input  cfa_sm9_pkg::t_frame_geom      i_geom,
    input  logic                          i_valid,
    input  logic [PIXEL_BITS-1:0]         i_pix,
    output logic                          o_ready,
    output logic                          o_sort_valid,
    input  logic                          i_sort_ready,
    output logic [8:0][PIXEL_BITS-1:0]    o_taps,
    output cfa_sm9_pkg::t_sort_ctl        o_ctl
);
    import cfa_sm9_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned PB    = PIXEL_BITS;
    localparam int unsigned LW    = 4 * PB;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_v;
    logic             r_ov;
    t_sort_ctl        r_ctl;
    logic [PB-1:0]    r_pix;
    logic [COL_W-1:0] r_wcol;
    logic [LW-1:0]    r_rd;
    logic [LW-1:0]    mem [MAX_WIDTH];
    logic [PB-1:0]    r_win [3][4];

    logic             w_acc;
    logic             w_adv;
    logic             w_ov;
    logic             w_int;
    logic             w_eof;
    logic [PB-1:0]    w_lane [4];
    logic [PB-1:0]    w_inc [3];
    logic [LW-1:0]    w_word;

    // position of the output pixel relative to the incoming one
    assign w_ov  = (r_col >= COL_W'(2)) ? (r_row >= ROW_W'(2)) : (r_row >= ROW_W'(3));
    assign w_int = (r_col >= COL_W'(4)) && (r_row >= ROW_W'(4)) && (r_row <= i_geom.h_m1);
    assign w_eof = (r_col == COL_W'(1)) && (r_row == i_geom.h_p2);

    assign w_adv   = r_v && (!r_ov || i_sort_ready);
    assign o_ready = !r_v || w_adv;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_geom.restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_acc) begin
            if (w_eof) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == i_w_m1) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v   <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_acc) begin
                r_v  <= 1'b1;
                r_ov <= w_ov;
            end else if (w_adv) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pix          <= i_pix;
            r_wcol         <= r_col;
            r_ctl.interior <= w_int;
            r_ctl.eof      <= w_eof;
        end
    end

    // line store: one word per column, four rows deep
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd <= mem[r_col];
        end
        if (w_adv) begin
            mem[r_wcol] <= w_word;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_lane[k] = r_rd[k*PB +: PB];
        end
    end

    assign w_word   = {w_lane[2], w_lane[1], w_lane[0], r_pix};
    assign w_inc[0] = w_lane[3];
    assign w_inc[1] = w_lane[1];
    assign w_inc[2] = r_pix;

    // window rows 0, 2 and 4, columns 0 to 3
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int rr = 0; rr < 3; rr++) begin
                for (int cc = 0; cc < 3; cc++) begin
                    r_win[rr][cc] <= r_win[rr][cc+1];
                end
                r_win[rr][3] <= w_inc[rr];
            end
        end
    end

    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            o_taps[3*rr]     = r_win[rr][0];
            o_taps[3*rr + 1] = r_win[rr][2];
            o_taps[3*rr + 2] = w_inc[rr];
        end
    end

    assign o_sort_valid = r_v && r_ov;
    assign o_ctl        = r_ctl;

endmodule

FILE: hw/rtl/cfa_sm9_sort.sv
// cfa_sm9_sort: pipelined median-of-nine compare-exchange network, an input stage,
// then one network layer per stage, last stage is the output register; uses cfa_sm9_pkg

module cfa_sm9_sort #(
    parameter int unsigned PIXEL_BITS = cfa_sm9_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [8:0][PIXEL_BITS-1:0]  i_taps,
    input  cfa_sm9_pkg::t_sort_ctl      i_ctl,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [PIXEL_BITS-1:0]       o_pix,
    output logic                        o_eof
);
    import cfa_sm9_pkg::*;

    localparam int unsigned PB  = PIXEL_BITS;
    localparam int unsigned STG = NET_LAYERS + 1;

    logic [STG-1:0]          r_v;
    logic [STG-1:0]          w_rdy;
    logic [8:0][PB-1:0]      r_vec [STG];
    t_sort_ctl               r_ctl [STG];

    function automatic logic [8:0][PB-1:0] cx_layer(input logic [8:0][PB-1:0] v,
                                                    input logic [3:0] lyr);
        logic [8:0][PB-1:0] o;
        logic [PB-1:0]      a;
        logic [PB-1:0]      b;
        o = v;
        for (int p = 0; p < NET_PAIRS; p++) begin
            if (2'(p) < NET_CNT[lyr]) begin
                a = o[NET_I[lyr][2'(p)]];
                b = o[NET_J[lyr][2'(p)]];
                if (b < a) begin
                    o[NET_I[lyr][2'(p)]] = b;
                    o[NET_J[lyr][2'(p)]] = a;
                end
            end
        end
        return o;
    endfunction

    assign w_rdy[STG-1] = !r_v[STG-1] || !i_stall;

    genvar s;
    generate
        for (s = 0; s < STG - 1; s++) begin : g_rdy
            assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_vec[0] <= i_taps;
            r_ctl[0] <= i_ctl;
        end
    end

    generate
        for (s = 1; s < STG; s++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end

            // border items pass unchanged so the centre sample comes out
            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    r_vec[s] <= r_ctl[s-1].interior ? cx_layer(r_vec[s-1], 4'(s - 1))
                                                    : r_vec[s-1];
                    r_ctl[s] <= r_ctl[s-1];
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[STG-1];
    assign o_pix   = r_vec[STG-1][4];
    assign o_eof   = r_ctl[STG-1].eof;

endmodule

FILE: hw/rtl/cfa_same_color_median9_core.sv
// cfa_same_color_median9_core: same-color 3x3 median filter for a bayer stream
// latency: a result passes the front-end pixel register and the sort network stage
// registers after the item that completes its window is accepted, and waits while the output stalls
// throughput: one item per cycle while the output does not stall, one line-store read and one write per item
// reset: counters cleared, width 1920, height 1080; no clearing pass, the
// line store and window need no initial value
// uses cfa_sm9_pkg, cfa_sm9_cfg, cfa_sm9_front, cfa_sm9_sort

module cfa_same_color_median9_core #(
    parameter int unsigned MAX_WIDTH  = cfa_sm9_pkg::MAX_WIDTH_DEF,
    parameter int unsigned PIXEL_BITS = cfa_sm9_pkg::PIXEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cfa_sm9_pkg::t_in_item           i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cfa_sm9_pkg::t_out_item          o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfa_sm9_pkg::CFG_AW-1:0]  paddr,
    input  logic [cfa_sm9_pkg::CFG_DW-1:0]  pwdata,
    output logic [cfa_sm9_pkg::CFG_DW-1:0]  prdata,
    output logic                            pready
);
    import cfa_sm9_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned PB    = PIXEL_BITS;

    logic [COL_W-1:0]   w_w_m1;
    t_frame_geom        w_geom;
    logic               w_in_ready;
    logic               w_sort_valid;
    logic               w_sort_ready;
    logic [8:0][PB-1:0] w_taps;
    t_sort_ctl          w_ctl;
    logic [PB-1:0]      w_pix_out;
    logic               w_eof;

    cfa_sm9_cfg #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_w_m1  (w_w_m1),
        .o_geom  (w_geom)
    );

    cfa_sm9_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_w_m1       (w_w_m1),
        .i_geom       (w_geom),
        .i_valid      (i_in_valid),
        .i_pix        (i_in_item.pixel_in[PB-1:0]),
        .o_ready      (w_in_ready),
        .o_sort_valid (w_sort_valid),
        .i_sort_ready (w_sort_ready),
        .o_taps       (w_taps),
        .o_ctl        (w_ctl)
    );

    cfa_sm9_sort #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sort_valid),
        .o_ready (w_sort_ready),
        .i_taps  (w_taps),
        .i_ctl   (w_ctl),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_pix   (w_pix_out),
        .o_eof   (w_eof)
    );

    assign o_in_stall              = !w_in_ready;
    assign o_out_item.pixel_out    = DATA_W'(w_pix_out);
    assign o_out_item.end_of_frame = w_eof;

endmodule

FILE: tb/sv/cfa_same_color_median9_core_tb.sv
// cfa_same_color_median9_core_tb: self-checking bench for the same-color median9 core
// streams bayer frames of many sizes with random gaps and stalls, predicts each item
// uses cfa_sm9_pkg and cfa_same_color_median9_core
`timescale 1ns / 1ps

module cfa_same_color_median9_core_tb;
    import cfa_sm9_pkg::*;

    localparam int unsigned LINE_MAX      = MAX_WIDTH_DEF;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_ITEMS  = 150;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_MIXED = 2;

    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_EXTREME = 1;
    localparam int STYLE_BAND    = 2;

    localparam logic [15:0] DIRECTED_PIX [25] = '{
        16'hFFFF, 16'h5555, 16'h0000, 16'hAAAA, 16'hFFFF,
        16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h0100,
        16'h0000, 16'h00FF, 16'h04D2, 16'hFF00, 16'hFFFF,
        16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 16'h0002,
        16'h0000, 16'h3C3C, 16'h0000, 16'hC3C3, 16'hFFFF
    };

    class median9_checker;
        bit [12:0]   width_raw;
        bit [14:0]   height_raw;
        bit [15:0]   lines [4][LINE_MAX];
        bit [15:0]   win [5][5];
        int unsigned col_pos;
        int unsigned row_pos;
        t_out_item   pending_pix [$];
        int unsigned n_fail;
        int unsigned n_taken;
        int unsigned n_checked;
        int unsigned n_median;
        int unsigned n_copied;
        int unsigned n_eof;

        function new();
            width_raw  = 13'(WIDTH_RESET);
            height_raw = 15'(HEIGHT_RESET);
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_raw;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > LINE_MAX) w = LINE_MAX;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_raw;
            if (h < MIN_DIM) h = MIN_DIM;
            if (h > HEIGHT_CAP) h = HEIGHT_CAP;
            return h;
        endfunction

        // any write restarts the frame
        function void set_reg(t_reg_idx idx, bit [31:0] val);
            case (idx)
                REG_LINE_WIDTH:   width_raw  = val[12:0];
                REG_FRAME_HEIGHT: height_raw = val[14:0];
                default: ;
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        function bit [15:0] median_of(input bit [15:0] s [9]);
            bit [15:0] v [9];
            bit [15:0] t;
            int i;
            int j;
            v = s;
            for (i = 1; i < 9; i++) begin
                t = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > t) begin
                    v[j+1] = v[j];
                    j--;
                end
                v[j+1] = t;
            end
            return v[4];
        endfunction

        function void take_input(t_in_item it);
            int unsigned w, h, ic, ir, orow, ocol;
            bit          hit;
            bit [15:0]   s [9];
            t_out_item   res;
            int          r, c;
            w  = eff_width();
            h  = eff_height();
            ic = col_pos;
            ir = row_pos;
            if (ic >= w) ic = 0;
            n_taken++;
            for (r = 0; r < 5; r++) begin
                for (c = 0; c < 4; c++) win[r][c] = win[r][c+1];
            end
            win[0][4] = lines[3][ic];
            win[1][4] = lines[2][ic];
            win[2][4] = lines[1][ic];
            win[3][4] = lines[0][ic];
            win[4][4] = it.pixel_in;
            lines[3][ic] = lines[2][ic];
            lines[2][ic] = lines[1][ic];
            lines[1][ic] = lines[0][ic];
            lines[0][ic] = it.pixel_in;

            hit  = 1'b0;
            orow = 0;
            ocol = 0;
            if (ic >= 2) begin
                if (ir >= 2) begin
                    hit  = 1'b1;
                    orow = ir - 2;
                    ocol = ic - 2;
                end
            end else if (ir >= 3) begin
                hit  = 1'b1;
                orow = ir - 3;
                ocol = w - 2 + ic;
            end

            ic++;
            if (ic >= w) begin
                ic = 0;
                ir++;
            end
            col_pos = ic;
            row_pos = ir;
            if (!hit) return;

            if (orow >= 2 && orow + 3 <= h && ocol >= 2 && ocol + 3 <= w) begin
                s = '{win[0][0], win[0][2], win[0][4],
                      win[2][0], win[2][2], win[2][4],
                      win[4][0], win[4][2], win[4][4]};
                res.pixel_out = median_of(s);
                n_median++;
            end else begin
                res.pixel_out = win[2][2];
                n_copied++;
            end
            res.end_of_frame = (orow + 1 == h) && (ocol + 1 == w);
            if (res.end_of_frame) begin
                col_pos = 0;
                row_pos = 0;
                n_eof++;
            end
            pending_pix.push_back(res);
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (pending_pix.size() == 0) begin
                $error("result with nothing pending: pixel_out %0d end_of_frame %0d",
                       got.pixel_out, got.end_of_frame);
                n_fail++;
                return;
            end
            want = pending_pix.pop_front();
            n_checked++;
            if (got.pixel_out !== want.pixel_out) begin
                $error("pixel_out mismatch: expected %0d, got %0d",
                       want.pixel_out, got.pixel_out);
                n_fail++;
            end
            if (got.end_of_frame !== want.end_of_frame) begin
                $error("end_of_frame mismatch: expected %0d, got %0d",
                       want.end_of_frame, got.end_of_frame);
                n_fail++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [CFG_DW-1:0]    pwdata;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    median9_checker sb;
    int          in_mode;
    int          out_mode;
    bit          hold_req;
    int unsigned band_base;
    int unsigned n_settings;
    int unsigned n_holds;
    int unsigned n_in_stalled;

    cfa_same_color_median9_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && !o_in_stall) sb.take_input(i_in_item);
            if (i_in_valid && o_in_stall) n_in_stalled++;
            if (o_out_valid && !i_out_stall) sb.check_output(o_out_item);
        end
    end

    function automatic int pick_idle(int mode);
        int r;
        if (mode == IDLE_NONE) return 0;
        r = $urandom_range(0, 99);
        if (mode == IDLE_LIGHT) return (r < 25) ? 1 : 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] next_pixel(int style);
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h8000;
                    3: return 16'h7FFF;
                    default: return 16'($urandom);
                endcase
            end
            STYLE_BAND: return 16'(band_base + $urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stalls, plus a long hold when asked
    initial begin
        int s;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                s = HOLD_CYCLES;
                n_holds++;
            end else begin
                s = pick_idle(out_mode);
            end
            if (s > 0) begin
                i_out_stall <= 1'b1;
                repeat (s) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_idle(in_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.pending_pix.size() != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic reconfigure(input logic [31:0] wval, input logic [31:0] hval);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_LINE_WIDTH, wval);
        write_reg(REG_FRAME_HEIGHT, hval);
        n_settings++;
    endtask

    // full frame plus flush pads, or only the first n_limit items of it
    task automatic feed_frame(input int style, input int n_limit, input int hold_at,
                              input int pause_at);
        int       w, h, total, k;
        t_in_item it;
        w = sb.eff_width();
        h = sb.eff_height();
        total = (h + 2) * w + 2;
        if (n_limit >= 0 && n_limit < total) total = n_limit;
        band_base = $urandom_range(0, 65532);
        for (k = 0; k < total; k++) begin
            if (k == hold_at) hold_req = 1'b1;
            if (k == pause_at) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            it.pixel_in = next_pixel(style);
            it.pad      = (k >= w * h);
            send_item(it);
        end
    endtask

    initial begin
        int unsigned rand_start;
        int          k, style, hold_at;
        logic [31:0] w_raw, h_raw;
        t_in_item    it;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        hold_req   = 1'b0;
        in_mode    = IDLE_NONE;
        out_mode   = IDLE_NONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest frame with extreme and tied samples, pads of both polarities
        reconfigure(5, 5);
        for (k = 0; k < 37; k++) begin
            it.pixel_in = (k < 25) ? DIRECTED_PIX[k] : ((k % 2) ? 16'hFFFF : 16'h0000);
            it.pad      = (k >= 25);
            send_item(it);
        end

        // clamped low sizes, back to back frames
        in_mode  = IDLE_MIXED;
        out_mode = IDLE_MIXED;
        reconfigure(0, 3);
        feed_frame(STYLE_RANDOM, -1, -1, -1);
        feed_frame(STYLE_EXTREME, -1, -1, -1);

        // long output hold while the input keeps coming
        in_mode = IDLE_NONE;
        reconfigure(6, 7);
        feed_frame(STYLE_RANDOM, -1, 20, -1);
        in_mode = IDLE_MIXED;
        feed_frame(STYLE_BAND, -1, -1, -1);

        // sender drains mid frame, then a write restarts the frame
        reconfigure(9, 6);
        feed_frame(STYLE_RANDOM, 50, -1, 30);
        reconfigure(9, 6);
        feed_frame(STYLE_EXTREME, -1, -1, -1);

        rand_start = sb.n_taken;
        while (sb.n_taken - rand_start < RANDOM_ITEMS) begin
            w_raw    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            h_raw    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
            in_mode  = $urandom_range(IDLE_NONE, IDLE_MIXED);
            out_mode = $urandom_range(IDLE_NONE, IDLE_MIXED);
            style    = $urandom_range(STYLE_RANDOM, STYLE_BAND);
            hold_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 80) : -1;
            reconfigure(w_raw, h_raw);
            if ($urandom_range(0, 4) == 0) begin
                feed_frame(style, $urandom_range(0, 60), hold_at, -1);
            end else begin
                repeat ($urandom_range(1, 2)) feed_frame(style, -1, hold_at, -1);
            end
        end

        // widest line and tallest frame from clamped all-ones writes, first items only
        in_mode  = IDLE_LIGHT;
        out_mode = IDLE_LIGHT;
        reconfigure(32'hFFFF_FFFF, 5);
        feed_frame(STYLE_RANDOM, 60, -1, -1);
        reconfigure(5, 32'hFFFF_FFFF);
        feed_frame(STYLE_RANDOM, 60, -1, -1);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("summary: %0d items in, %0d results checked (%0d medians, %0d copied, %0d eof)",
                 sb.n_taken, sb.n_checked, sb.n_median, sb.n_copied, sb.n_eof);
        $display("summary: %0d register settings, input stalled %0d cycles, %0d long holds",
                 n_settings, n_in_stalled, n_holds);
        if (sb.n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
